/* src/sptl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptl_pkg
// Shared types, sizes and the sequencer control store for the sorted point
// table lookup.
// ----------------------------------------------------------------------------
package sptl_pkg;

   localparam int IDX_W       = 12;
   localparam int TABLE_DEPTH = 1 << IDX_W;
   localparam int COORD_WIDTH = 32;
   localparam int CNT_W       = IDX_W + 1;   // holds 0 .. TABLE_DEPTH
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = IDX_W;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_LOW  = 1'b0,
      CSR_RANGE_HIGH = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic                          op;
      logic [IDX_W-1:0]              entry_index;
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
      logic signed [COORD_WIDTH-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] match_index;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } point_type;

   // Program steps; the step counter wraps from the last step to the first.
   typedef enum logic [1:0] {
      STEP_IDLE  = 2'd0,
      STEP_PROBE = 2'd1,
      STEP_CMP   = 2'd2,
      STEP_EMIT  = 2'd3
   } step_type;

   // Jump conditions: taken jumps to the target, else fall through to step+1.
   typedef enum logic [1:0] {
      JC_NOT_QUERY = 2'd0,
      JC_EMPTY     = 2'd1,
      JC_NOT_EQUAL = 2'd2,
      JC_OUT_BUSY  = 2'd3
   } jcond_type;

   typedef struct packed {
      jcond_type jcond;
      step_type  target;
      logic      take_req;   // open the request channel
      logic      mem_rd;     // read the table at the midpoint
      logic      cmp_en;     // compare and narrow the window
      logic      emit_en;    // hand the result to the output register
   } ctl_word_type;

   function automatic ctl_word_type ctl_rom(input step_type step);
      ctl_word_type w;
      begin
         w = '{jcond: JC_NOT_QUERY, target: STEP_IDLE, take_req: 1'b0,
               mem_rd: 1'b0, cmp_en: 1'b0, emit_en: 1'b0};
         case (step)
            STEP_IDLE: begin
               w.jcond = JC_NOT_QUERY;  w.target = STEP_IDLE;  w.take_req = 1'b1;
            end
            STEP_PROBE: begin
               w.jcond = JC_EMPTY;      w.target = STEP_EMIT;  w.mem_rd = 1'b1;
            end
            STEP_CMP: begin
               w.jcond = JC_NOT_EQUAL;  w.target = STEP_PROBE; w.cmp_en = 1'b1;
            end
            STEP_EMIT: begin
               w.jcond = JC_OUT_BUSY;   w.target = STEP_EMIT;  w.emit_en = 1'b1;
            end
            default: begin
               w.jcond = JC_NOT_QUERY;  w.target = STEP_IDLE;
            end
         endcase
         return w;
      end
   endfunction

endpackage

/* src/sorted_point_table_lookup.sv */
`timescale 1ns / 1ps
// Timing: a load is written at the edge that accepts it; a query runs a probe and a
//   compare step per search level, L <= 13 over 4096 entries, and registers its
//   result in the emit step; a miss ends on a probe that finds the window empty.
// Throughput: loads back to back; a query holds the input until its result is
//   registered in the output slot, and only then is the next request taken.
// Reset: synchronous; clears sequencer, ranges, found flag and output valid, not the table.
// ----------------------------------------------------------------------------
// sorted_point_table_lookup
// Binary search of (x,y,z) over a table sorted lexicographically, driven by a
// four-step microprogram over a plain window/compare datapath.
// ----------------------------------------------------------------------------
module sorted_point_table_lookup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sptl_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sptl_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_we,
   input  logic [sptl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sptl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sptl_pkg::*;

   // Sequencer
   step_type     step_ff, step_in;
   ctl_word_type ctl;
   logic         jump_taken;

   // Configuration
   logic [IDX_W-1:0] range_low_ff, range_low_in;
   logic [IDX_W-1:0] range_high_ff, range_high_in;

   // Search window: lo .. hi_end-1, both may reach TABLE_DEPTH
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_end_ff, hi_end_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] span;
   logic             window_empty;

   point_type key_ff, key_in;
   point_type rd_data_ff;
   point_type req_point;

   logic             found_ff, found_in;
   logic [IDX_W-1:0] match_ff, match_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic req_accept, query_accept, load_accept;
   logic out_busy;
   logic entry_lt, entry_eq;

   // Point table: written by loads, read once per search level
   point_type point_table [TABLE_DEPTH];

   // ------------------------------------------------------------------------
   // Control word and handshake
   // ------------------------------------------------------------------------
   assign ctl          = ctl_rom(step_ff);
   assign req_stall    = !ctl.take_req;
   assign req_accept   = req_valid && ctl.take_req;
   assign query_accept = req_accept && (req_payload.op == OP_QUERY);
   assign load_accept  = req_accept && (req_payload.op == OP_LOAD);
   assign out_busy     = rsp_valid_ff && rsp_stall;

   assign req_point.x = req_payload.coord_x;
   assign req_point.y = req_payload.coord_y;
   assign req_point.z = req_payload.coord_z;

   // Window arithmetic: mid = lo + (hi - lo) / 2 with hi = hi_end - 1
   assign window_empty = (lo_ff >= hi_end_ff);
   assign span         = hi_end_ff - lo_ff - CNT_W'(1);
   assign mid_in       = IDX_W'(lo_ff + (span >> 1));

   // Lexicographic compare of the probed entry against the key
   always_comb begin
      entry_eq = (rd_data_ff == key_ff);
      if (rd_data_ff.x != key_ff.x) begin
         entry_lt = (rd_data_ff.x < key_ff.x);
      end else if (rd_data_ff.y != key_ff.y) begin
         entry_lt = (rd_data_ff.y < key_ff.y);
      end else begin
         entry_lt = (rd_data_ff.z < key_ff.z);
      end
   end

   // ------------------------------------------------------------------------
   // Next step: conditional jump or fall through (wraps after EMIT)
   // ------------------------------------------------------------------------
   always_comb begin
      case (ctl.jcond)
         JC_NOT_QUERY: jump_taken = !query_accept;
         JC_EMPTY:     jump_taken = window_empty;
         JC_NOT_EQUAL: jump_taken = !entry_eq;
         JC_OUT_BUSY:  jump_taken = out_busy;
         default:      jump_taken = 1'b0;
      endcase
      if (jump_taken) begin
         step_in = ctl.target;
      end else begin
         step_in = step_type'(step_ff + 2'd1);
      end
   end

   // ------------------------------------------------------------------------
   // Datapath controls
   // ------------------------------------------------------------------------
   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      lo_in         = lo_ff;
      hi_end_in     = hi_end_ff;
      key_in        = key_ff;
      found_in      = found_ff;
      match_in      = match_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_RANGE_LOW:  range_low_in  = csr_wdata;
            CSR_RANGE_HIGH: range_high_in = csr_wdata;
            default:        range_low_in  = range_low_ff;
         endcase
      end

      // Start a query: latch key, open the window over the configured range, clear the result
      if (query_accept) begin
         key_in    = req_point;
         lo_in     = {1'b0, range_low_ff};
         hi_end_in = {1'b0, range_high_ff} + CNT_W'(1);
         found_in  = 1'b0;
         match_in  = '0;
      end

      // Narrow the window, or record the hit
      if (ctl.cmp_en) begin
         if (entry_eq) begin
            found_in = 1'b1;
            match_in = mid_ff;
         end else if (entry_lt) begin
            lo_in = {1'b0, mid_ff} + CNT_W'(1);
         end else begin
            hi_end_in = {1'b0, mid_ff};
         end
      end

      // Drop the taken result, then load a new one when the slot is free
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.emit_en && !out_busy) begin
         rsp_valid_in      = 1'b1;
         rsp_in.found       = found_ff;
         rsp_in.match_index = match_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_IDLE;
         range_low_ff  <= '0;
         range_high_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         step_ff       <= step_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_end_ff <= hi_end_in;
      key_ff    <= key_in;
      match_ff  <= match_in;
      rsp_ff    <= rsp_in;
      if (ctl.mem_rd) begin
         mid_ff <= mid_in;
      end
   end

   // Table memory: one write port for loads, one registered read at mid
   always_ff @(posedge clock) begin
      if (load_accept) begin
         point_table[req_payload.entry_index] <= req_point;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_rd) begin
         rd_data_ff <= point_table[mid_in];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // A result appears only out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff == STEP_EMIT))
      else $error("result raised outside emit step");

   // Every compare follows a probe, so the read data belongs to mid
   a_cmp_after_probe: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_CMP) |-> $past(step_ff == STEP_PROBE))
      else $error("compare without a preceding probe");

   // A miss always reports index zero
   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.match_index == '0))
      else $error("miss carries a nonzero index");

   // The window end never passes the table depth during a search
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_PROBE) |-> (hi_end_ff <= CNT_W'(TABLE_DEPTH)))
      else $error("search window beyond table");
`endif

endmodule
